[hdl/tbc_pkg.sv]
// Shared constants, types, divider step and saturation for the barycentric coordinates.
package tbc_pkg;

   localparam int CoordWidth  = 16;
   localparam int NumCoords   = 12;
   localparam int WeightWidth = 32;
   localparam int DiffWidth   = CoordWidth + 1;
   localparam int ProdWidth   = 2 * DiffWidth;
   localparam int DotWidth    = ProdWidth + 1;
   localparam int PartWidth   = 18;
   localparam int WideWidth   = 2 * DotWidth;
   localparam int DenWidth    = WideWidth;
   localparam int FracBits    = 16;
   localparam int QuoWidth    = WeightWidth;
   localparam int NumDiv      = QuoWidth;
   localparam int NumStages   = NumDiv + 10;
   localparam int ReqWidth    = NumCoords * CoordWidth;
   localparam int RspWidth    = 3 * WeightWidth;
   localparam int OneQ16      = 65536;

   typedef struct packed {
      logic [DenWidth-1:0] rem;
      logic [QuoWidth-1:0] nlo;
      logic [QuoWidth-1:0] quo;
      logic                ovf;
      logic                neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type        lane_v;
      div_lane_type        lane_w;
      logic [DenWidth-1:0] den;
      logic                degen;
   } div_pipe_type;

   // one restoring-division step: shift in the next numerator bit, compare, subtract
   function automatic div_lane_type div_step(div_lane_type l, logic [DenWidth-1:0] den);
      logic [DenWidth:0] r2;
      logic              ge;
      div_lane_type      r;
      r2 = {l.rem, l.nlo[QuoWidth-1]};
      ge = (r2 >= {1'b0, den});
      r = l;
      r.rem = ge ? DenWidth'(r2 - {1'b0, den}) : r2[DenWidth-1:0];
      r.nlo = {l.nlo[QuoWidth-2:0], 1'b0};
      r.quo = {l.quo[QuoWidth-2:0], ge};
      return r;
   endfunction

   // apply sign and saturate the 32-bit quotient magnitude
   function automatic logic signed [WeightWidth-1:0] sat_weight(div_lane_type l);
      logic [QuoWidth-1:0] lim;
      logic [QuoWidth-1:0] q;
      logic [QuoWidth:0]   s;
      lim = l.neg ? {1'b1, {(QuoWidth-1){1'b0}}} : {1'b0, {(QuoWidth-1){1'b1}}};
      q = (l.ovf || (l.quo > lim)) ? lim : l.quo;
      s = l.neg ? ((QuoWidth+1)'(0) - {1'b0, q}) : {1'b0, q};
      return s[WeightWidth-1:0];
   endfunction

endpackage

[hdl/triangle_barycentric_coords.sv]
// Pipelined barycentric coordinates of a point against a 3D triangle, Q8.8 in, Q16.16 out.
//
// Input channel req_*: one item per handshake holds vertices A, B, C and point P,
// twelve signed Q8.8 coordinates packed in req_tdata.
// Result channel rsp_*: one item per input item, weights u, v, w in signed Q16.16
// (truncated toward zero, saturated) in rsp_tdata, and the degenerate flag in
// rsp_tuser. A degenerate triangle gives all weights zero.
// Throughput: one item per cycle unless the pipeline is full and the receiver stalls.
// 42 register stages, of which 32 are the one-bit-per-stage restoring dividers for v
// and w, sized by the 32-bit quotient. Each stage holds a valid bit and advances
// when it, or any stage after it, is empty or the receiver is ready, so bubbles
// close up and req_tready stays high while space remains. When the receiver stalls
// the output register holds its item and the pipeline fills; req_tready falls only
// when all 42 stages hold items.
// Reset clears all valid bits; the pipeline is then empty and ready.
module triangle_barycentric_coords (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, point_x, point_y, point_z
   input  logic [tbc_pkg::ReqWidth-1:0]  req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // weight_u, weight_v, weight_w
   output logic [tbc_pkg::RspWidth-1:0]  rsp_tdata,
   // degenerate
   output logic                          rsp_tuser
);

   localparam int NST = tbc_pkg::NumStages;
   localparam int DW  = tbc_pkg::DiffWidth;
   localparam int PW  = tbc_pkg::ProdWidth;
   localparam int OW  = tbc_pkg::DotWidth;
   localparam int HW  = tbc_pkg::PartWidth;
   localparam int WW  = tbc_pkg::WideWidth;
   localparam int ND  = tbc_pkg::NumDiv;
   localparam int WT  = tbc_pkg::WeightWidth;
   localparam int CW  = tbc_pkg::CoordWidth;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;

   genvar gk;
   generate
      for (gk = 0; gk < NST; gk++) begin : g_en
         assign en[gk] = !(&vld_ff[NST-1:gk]) || rsp_tready;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // stage 0: edge vectors
   logic signed [DW-1:0] ab_ff [3];
   logic signed [DW-1:0] ac_ff [3];
   logic signed [DW-1:0] ap_ff [3];
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= DW'($signed(req_tdata[CW*(3+i) +: CW]))
                      - DW'($signed(req_tdata[CW*i +: CW]));
            ac_ff[i] <= DW'($signed(req_tdata[CW*(6+i) +: CW]))
                      - DW'($signed(req_tdata[CW*i +: CW]));
            ap_ff[i] <= DW'($signed(req_tdata[CW*(9+i) +: CW]))
                      - DW'($signed(req_tdata[CW*i +: CW]));
         end
      end
   end

   // stage 1: component products; order bb, bc, cc, pb, pc
   logic signed [PW-1:0] prod_ff [5][3];
   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[0][i] <= ab_ff[i] * ab_ff[i];
            prod_ff[1][i] <= ab_ff[i] * ac_ff[i];
            prod_ff[2][i] <= ac_ff[i] * ac_ff[i];
            prod_ff[3][i] <= ap_ff[i] * ab_ff[i];
            prod_ff[4][i] <= ap_ff[i] * ac_ff[i];
         end
      end
   end

   // stage 2: dot products
   logic signed [OW-1:0] dot_ff [5];
   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int d = 0; d < 5; d++) begin
            dot_ff[d] <= OW'(prod_ff[d][0]) + OW'(prod_ff[d][1]) + OW'(prod_ff[d][2]);
         end
      end
   end

   // stage 3: partial products of the six wide multiplies
   // den = bb*cc - bc*bc, nv = cc*pb - bc*pc, nw = bb*pc - bc*pb
   localparam int XA [6] = '{0, 1, 2, 1, 0, 1};
   localparam int XB [6] = '{2, 1, 3, 4, 4, 3};
   localparam int UW = OW - HW;
   logic signed [2*UW-1:0]   phh_ff [6];
   logic signed [UW+HW:0]    phl_ff [6];
   logic signed [UW+HW:0]    plh_ff [6];
   logic        [2*HW-1:0]   pll_ff [6];
   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int m = 0; m < 6; m++) begin
            phh_ff[m] <= $signed(dot_ff[XA[m]][OW-1:HW]) * $signed(dot_ff[XB[m]][OW-1:HW]);
            phl_ff[m] <= $signed(dot_ff[XA[m]][OW-1:HW])
                       * $signed({1'b0, dot_ff[XB[m]][HW-1:0]});
            plh_ff[m] <= $signed({1'b0, dot_ff[XA[m]][HW-1:0]})
                       * $signed(dot_ff[XB[m]][OW-1:HW]);
            pll_ff[m] <= dot_ff[XA[m]][HW-1:0] * dot_ff[XB[m]][HW-1:0];
         end
      end
   end

   // stage 4: full products
   logic signed [WW-1:0] wide_ff [6];
   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int m = 0; m < 6; m++) begin
            wide_ff[m] <= (WW'(phh_ff[m]) <<< (2*HW))
                        + ((WW'(phl_ff[m]) + WW'(plh_ff[m])) <<< HW)
                        + $signed({{(WW-2*HW){1'b0}}, pll_ff[m]});
         end
      end
   end

   // stage 5: denominator and numerators
   logic signed [WW:0] den_ff;
   logic signed [WW:0] nv_ff;
   logic signed [WW:0] nw_ff;
   always_ff @(posedge clock) begin
      if (en[5]) begin
         den_ff <= (WW+1)'(wide_ff[0]) - (WW+1)'(wide_ff[1]);
         nv_ff  <= (WW+1)'(wide_ff[2]) - (WW+1)'(wide_ff[3]);
         nw_ff  <= (WW+1)'(wide_ff[4]) - (WW+1)'(wide_ff[5]);
      end
   end

   // stage 6: signs and magnitudes (den is never negative)
   logic [WW:0]   mv_ff;
   logic [WW:0]   mw_ff;
   logic          sv_ff;
   logic          sw_ff;
   logic [WW-1:0] dm_ff;
   logic          dg_ff;
   always_ff @(posedge clock) begin
      if (en[6]) begin
         sv_ff <= nv_ff[WW];
         sw_ff <= nw_ff[WW];
         mv_ff <= nv_ff[WW] ? ((WW+1)'(0) - nv_ff) : nv_ff;
         mw_ff <= nw_ff[WW] ? ((WW+1)'(0) - nw_ff) : nw_ff;
         dm_ff <= den_ff[WW-1:0];
         dg_ff <= (den_ff == '0);
      end
   end

   // stage 7: divider setup and overflow check; stages 8.. divider steps
   localparam int FB = tbc_pkg::FracBits;
   localparam int QW = tbc_pkg::QuoWidth;
   tbc_pkg::div_pipe_type div_ff [ND+1];
   always_ff @(posedge clock) begin
      if (en[7]) begin
         div_ff[0].den          <= dm_ff;
         div_ff[0].degen        <= dg_ff;
         div_ff[0].lane_v.neg   <= sv_ff;
         div_ff[0].lane_w.neg   <= sw_ff;
         div_ff[0].lane_v.ovf   <= ({{FB{1'b0}}, mv_ff[WW:FB]} >= {1'b0, dm_ff});
         div_ff[0].lane_w.ovf   <= ({{FB{1'b0}}, mw_ff[WW:FB]} >= {1'b0, dm_ff});
         div_ff[0].lane_v.rem   <= WW'(mv_ff[WW:FB]);
         div_ff[0].lane_w.rem   <= WW'(mw_ff[WW:FB]);
         div_ff[0].lane_v.nlo   <= {mv_ff[FB-1:0], {(QW-FB){1'b0}}};
         div_ff[0].lane_w.nlo   <= {mw_ff[FB-1:0], {(QW-FB){1'b0}}};
         div_ff[0].lane_v.quo   <= '0;
         div_ff[0].lane_w.quo   <= '0;
      end
      for (int s = 0; s < ND; s++) begin
         if (en[8+s]) begin
            div_ff[s+1].den    <= div_ff[s].den;
            div_ff[s+1].degen  <= div_ff[s].degen;
            div_ff[s+1].lane_v <= tbc_pkg::div_step(div_ff[s].lane_v, div_ff[s].den);
            div_ff[s+1].lane_w <= tbc_pkg::div_step(div_ff[s].lane_w, div_ff[s].den);
         end
      end
   end

   // stage ND+8: signed, saturated v and w
   logic signed [WT-1:0] v_ff;
   logic signed [WT-1:0] w_ff;
   logic                 fdg_ff;
   always_ff @(posedge clock) begin
      if (en[ND+8]) begin
         v_ff   <= div_ff[ND].degen ? '0 : tbc_pkg::sat_weight(div_ff[ND].lane_v);
         w_ff   <= div_ff[ND].degen ? '0 : tbc_pkg::sat_weight(div_ff[ND].lane_w);
         fdg_ff <= div_ff[ND].degen;
      end
   end

   // stage ND+9: u = 1 - v - w, output register
   logic signed [WT+1:0] u_wide;
   logic signed [WT-1:0] u_sat;
   assign u_wide = (WT+2)'(tbc_pkg::OneQ16) - (WT+2)'(v_ff) - (WT+2)'(w_ff);
   always_comb begin
      if (u_wide > $signed({3'b000, {(WT-1){1'b1}}})) begin
         u_sat = {1'b0, {(WT-1){1'b1}}};
      end else if (u_wide < $signed({3'b111, {(WT-1){1'b0}}})) begin
         u_sat = {1'b1, {(WT-1){1'b0}}};
      end else begin
         u_sat = u_wide[WT-1:0];
      end
   end

   logic [tbc_pkg::RspWidth-1:0] out_ff;
   logic                         odg_ff;
   always_ff @(posedge clock) begin
      if (en[ND+9]) begin
         out_ff <= {w_ff, v_ff, fdg_ff ? {WT{1'b0}} : u_sat};
         odg_ff <= fdg_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = odg_ff;

`ifndef SYNTHESIS
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate item with nonzero weights");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> req_tready)
      else $error("input stalled with an empty first stage");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] && !rsp_tready && (&vld_ff) |=> !$past(req_tready))
      else $error("full pipeline accepted an item");
`endif

endmodule
